/* design/xtea_block_cipher_assert.svh */
// ---------------------------------------------------------------------------
// XTEA block cipher assertion macros
// Shared property forms for the concurrent checks in the cipher modules.
// ---------------------------------------------------------------------------
`ifndef XTEA_BLOCK_CIPHER_ASSERT_SVH
`define XTEA_BLOCK_CIPHER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define XTEA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("xtea same-cycle check failed");

// Next-cycle implication, checked outside reset
`define XTEA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("xtea next-cycle check failed");

`endif

/* design/xtea_pkg.sv */
// ---------------------------------------------------------------------------
// XTEA package
// Types, constants and round functions shared by the cipher modules.
// ---------------------------------------------------------------------------
package xtea_pkg;

	localparam logic [31:0] DELTA      = 32'h9E37_79B9;
	localparam logic [5:0]  MAX_ROUNDS = 6'd32;

	// Configuration register indexes
	localparam logic [2:0] CFG_KEY0   = 3'd0;
	localparam logic [2:0] CFG_KEY1   = 3'd1;
	localparam logic [2:0] CFG_KEY2   = 3'd2;
	localparam logic [2:0] CFG_KEY3   = 3'd3;
	localparam logic [2:0] CFG_ROUNDS = 3'd4;

	// Operation codes
	localparam logic OP_ENC = 1'b0;
	localparam logic OP_DEC = 1'b1;

	typedef logic [3:0][31:0] key_t;

	// One queued request, ready for the round engine
	typedef struct packed {
		logic        op;
		logic [31:0] left;
		logic [31:0] right;
		logic [5:0]  rounds;
		logic [31:0] sum;
	} job_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} core_state_t;

	// Feistel mixing of one half with its subkey
	function automatic logic [31:0] mix_half(input logic [31:0] v, input logic [31:0] sub);
		mix_half = ((((v << 4) ^ (v >> 5)) + v) ^ sub);
	endfunction

endpackage

/* design/xtea_front.sv */
// ---------------------------------------------------------------------------
// XTEA front end
// Holds the key and round count registers and turns each accepted request
// into a job: split halves, clamp the round count, start sum for decrypt.
// ---------------------------------------------------------------------------
module xtea_front import xtea_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        op,
	input  logic [63:0] block_in,
	output job_t        job,
	output key_t        key
);

	key_t        key_q;
	logic [5:0]  rounds_q;
	logic [5:0]  rounds_eff;
	logic [31:0] dec_sum;

	assign cfg_ready = 1'b1;
	assign key       = key_q;

	// Register writes; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q    <= '0;
			rounds_q <= MAX_ROUNDS;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_KEY0:   key_q[0] <= cfg_data;
				CFG_KEY1:   key_q[1] <= cfg_data;
				CFG_KEY2:   key_q[2] <= cfg_data;
				CFG_KEY3:   key_q[3] <= cfg_data;
				CFG_ROUNDS: rounds_q <= cfg_data[5:0];
				default:    ;
			endcase
		end
	end

	// Clamp the round count and derive the decrypt start sum
	always_comb begin
		rounds_eff = (rounds_q > MAX_ROUNDS) ? MAX_ROUNDS : rounds_q;
		dec_sum    = 32'(DELTA * {26'd0, rounds_eff});
	end

	// Build the job
	always_comb begin
		job.op     = op;
		job.left   = block_in[63:32];
		job.right  = block_in[31:0];
		job.rounds = rounds_eff;
		job.sum    = (op == OP_DEC) ? dec_sum : 32'd0;
	end

endmodule

/* design/xtea_queue.sv */
// ---------------------------------------------------------------------------
// XTEA job queue
// Short register queue between front end and round engine.
// ---------------------------------------------------------------------------
`include "xtea_block_cipher_assert.svh"

module xtea_queue import xtea_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_data,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output job_t pop_data
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	job_t            entries_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
		ptr_next = (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full      = (count_q == CntW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = entries_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop)  rd_ptr_q <= ptr_next(rd_ptr_q);
			priority if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push)     count_q <= count_q - 1'b1;
			else                       count_q <= count_q;
		end
	end

	// Store the pushed job
	always_ff @(posedge clk) begin
		if (push) entries_q[wr_ptr_q] <= push_data;
	end

	`XTEA_ASSERT_IMP(a_no_push_full, clk, arst_n, full, !push)
	`XTEA_ASSERT_IMP(a_no_pop_empty, clk, arst_n, !not_empty, !pop)

endmodule

/* design/xtea_core.sv */
// ---------------------------------------------------------------------------
// XTEA round engine
// Takes jobs from the queue and runs one full Feistel round per cycle,
// then parks the block in the output register.
// ---------------------------------------------------------------------------
`include "xtea_block_cipher_assert.svh"

module xtea_core import xtea_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  key_t        key,
	input  logic        job_valid,
	input  job_t        job,
	output logic        job_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] block_out
);

	core_state_t state_q;
	core_state_t state_nx;
	logic        op_q;
	logic [31:0] left_q;
	logic [31:0] right_q;
	logic [31:0] sum_q;
	logic [5:0]  cnt_q;
	logic        out_valid_q;
	logic [63:0] out_block_q;

	logic        out_free;
	logic        step;
	logic        finish;
	logic [31:0] sum_nx;
	logic [31:0] sub_a;
	logic [31:0] sub_b;
	logic [31:0] left_nx;
	logic [31:0] right_nx;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign block_out = out_block_q;

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: if (job_valid) state_nx = ST_RUN;
			ST_RUN:  if (cnt_q == '0 && out_free) state_nx = ST_IDLE;
			default: state_nx = ST_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		job_pop = 1'b0;
		step    = 1'b0;
		finish  = 1'b0;
		unique case (state_q)
			ST_IDLE: job_pop = job_valid;
			ST_RUN: begin
				step   = (cnt_q != '0);
				finish = (cnt_q == '0) && out_free;
			end
			default: ;
		endcase
	end

	// One round: first half-round at the current sum, second at the stepped sum
	always_comb begin
		if (op_q == OP_ENC) begin
			sum_nx   = sum_q + DELTA;
			sub_a    = sum_q + key[sum_q[1:0]];
			sub_b    = sum_nx + key[sum_nx[12:11]];
			left_nx  = left_q + mix_half(right_q, sub_a);
			right_nx = right_q + mix_half(left_nx, sub_b);
		end else begin
			sum_nx   = sum_q - DELTA;
			sub_a    = sum_q + key[sum_q[12:11]];
			sub_b    = sum_nx + key[sum_nx[1:0]];
			right_nx = right_q - mix_half(left_q, sub_a);
			left_nx  = left_q - mix_half(right_nx, sub_b);
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (job_pop)   cnt_q <= job.rounds;
			else if (step) cnt_q <= cnt_q - 1'b1;
			if (finish)          out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// Load and advance the block
	always_ff @(posedge clk) begin
		if (job_pop) begin
			op_q    <= job.op;
			left_q  <= job.left;
			right_q <= job.right;
			sum_q   <= job.sum;
		end else if (step) begin
			left_q  <= left_nx;
			right_q <= right_nx;
			sum_q   <= sum_nx;
		end
		if (finish) out_block_q <= {left_q, right_q};
	end

	`XTEA_ASSERT_IMP(a_pop_only_idle, clk, arst_n, job_pop, state_q == ST_IDLE)
	`XTEA_ASSERT_NXT(a_cnt_steps, clk, arst_n, step, cnt_q == $past(cnt_q) - 6'd1)
	`XTEA_ASSERT_IMP(a_cnt_bound, clk, arst_n, state_q == ST_RUN, cnt_q <= MAX_ROUNDS)
	`XTEA_ASSERT_IMP(a_finish_free, clk, arst_n, finish, !out_valid_q || !out_stall)

endmodule

/* design/xtea_block_cipher.sv */
// ---------------------------------------------------------------------------
// XTEA block cipher
// 64-bit block, 128-bit key, 0 to 32 rounds; encrypt or decrypt per request.
//
//   channel  | handshake              | payload
//   ---------+------------------------+--------------------------
//   input    | in_valid / in_stall    | op, block_in
//   output   | out_valid / out_stall  | block_out
//   config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// The round engine loads a request, runs its n rounds (n = clamped round count)
// on the single round unit, then moves the block to the output register, and
// takes the next request only after that.
// The front end accepts while the queue has room, also while the engine runs.
// Reset clears the queue, the engine and the output; key resets to zero and
// the round count to 32. out_stall holds the result and backs up the queue.
// ---------------------------------------------------------------------------
module xtea_block_cipher import xtea_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [63:0] block_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] block_out,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	job_t front_job;
	job_t core_job;
	key_t key;
	logic q_full;
	logic q_not_empty;
	logic q_pop;
	logic q_push;

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	xtea_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.op        (op),
		.block_in  (block_in),
		.job       (front_job),
		.key       (key)
	);

	xtea_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (front_job),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_data  (core_job)
	);

	xtea_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.key       (key),
		.job_valid (q_not_empty),
		.job       (core_job),
		.job_pop   (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.block_out (block_out)
	);

endmodule

/* bench/tb_xtea_block_cipher.sv */
// ---------------------------------------------------------------------------
// XTEA block cipher testbench
// Walks a table of directed vectors, then random phases with fresh keys and
// round counts under varying input gaps and output stalls. Every result is
// checked in order against a stored known block or a local XTEA transform of the accepted request.
// ---------------------------------------------------------------------------
module tb_xtea_block_cipher;
	import xtea_pkg::*;

	localparam int          WATCHDOG_LIMIT   = 5000;
	localparam int          SETTLE_CYCLES    = 40;
	localparam int          LONG_HOLD_CYCLES = 300;
	localparam int          PHASE_COUNT      = 8;
	localparam int          PHASE_ITEMS      = 190;
	localparam logic [2:0]  CFG_SPARE_FIRST  = CFG_ROUNDS + 3'd1;
	localparam logic [2:0]  CFG_SPARE_LAST   = 3'd7;
	localparam logic [63:0] ALL_ONES         = 64'hFFFF_FFFF_FFFF_FFFF;

	// One directed vector; key word0 sits in the top 32 bits of key
	typedef struct {
		logic [5:0]   rounds;
		logic [127:0] key;
		logic         dir;
		logic [63:0]  blk;
		bit           known;
		logic [63:0]  known_out;
	} cipher_vector_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        op = OP_ENC;
	logic [63:0] block_in = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] block_out;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = CFG_KEY0;
	logic [31:0] cfg_data = '0;

	// Local copy of the cipher settings, reset values first
	logic [31:0] model_key [4] = '{default: '0};
	logic [5:0]  model_rounds = MAX_ROUNDS;

	logic [63:0]    expected_blocks [$];
	cipher_vector_t cipher_vectors [$];
	int             error_count = 0;
	int             sender_idle_pct = 0;
	int             stall_pct = 0;
	bit             long_hold_armed = 1'b0;
	bit             long_hold_taken = 1'b0;
	int             hold_left = 0;
	int             quiet_cycles = 0;

	xtea_block_cipher dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.block_in  (block_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.block_out (block_out),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// Feistel half update: shifted mix of v, xored with sum plus key word
	function automatic logic [31:0] round_mix(input logic [31:0] v, input logic [31:0] s,
			input logic [31:0] k);
		round_mix = ((((v << 4) ^ (v >> 5)) + v) ^ (s + k));
	endfunction

	// Expected block for one request under the current settings
	function automatic logic [63:0] xtea_transform(input logic dir, input logic [63:0] blk);
		logic [31:0] l;
		logic [31:0] r;
		logic [31:0] s;
		int          n;
		l = blk[63:32];
		r = blk[31:0];
		n = (model_rounds > MAX_ROUNDS) ? int'(MAX_ROUNDS) : int'(model_rounds);
		if (dir == OP_ENC) begin
			s = '0;
			for (int i = 0; i < n; i++) begin
				l = l + round_mix(r, s, model_key[s[1:0]]);
				s = s + DELTA;
				r = r + round_mix(l, s, model_key[s[12:11]]);
			end
		end else begin
			s = 32'(DELTA * 32'(n));
			for (int i = 0; i < n; i++) begin
				r = r - round_mix(l, s, model_key[s[12:11]]);
				s = s - DELTA;
				l = l - round_mix(r, s, model_key[s[1:0]]);
			end
		end
		xtea_transform = {l, r};
	endfunction

	function automatic cipher_vector_t cipher_vector(input logic [5:0] rounds,
			input logic [127:0] key, input logic dir, input logic [63:0] blk,
			input bit known, input logic [63:0] known_out);
		cipher_vector_t v;
		v.rounds    = rounds;
		v.key       = key;
		v.dir       = dir;
		v.blk       = blk;
		v.known     = known;
		v.known_out = known_out;
		cipher_vector = v;
	endfunction

	function automatic logic [63:0] random_block();
		int unsigned sel;
		int unsigned bitpos;
		sel    = $urandom_range(0, 9);
		bitpos = $urandom_range(0, 63);
		case (sel)
			0: random_block = '0;
			1: random_block = ALL_ONES;
			2: random_block = 64'd1 << bitpos;
			3: random_block = ~(64'd1 << bitpos);
			default: random_block = {$urandom(), $urandom()};
		endcase
	endfunction

	// Write one register and mirror it into the local settings
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx <= CFG_KEY3) begin
			model_key[idx[1:0]] = data;
		end else if (idx == CFG_ROUNDS) begin
			model_rounds = data[5:0];
		end
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_cipher(input logic [127:0] key, input logic [5:0] rounds,
			input logic [25:0] pad);
		for (int i = 0; i < 4; i++) begin
			write_reg(3'(CFG_KEY0 + i), key[127 - 32 * i -: 32]);
		end
		write_reg(CFG_ROUNDS, {pad, rounds});
	endtask

	// Offer one request after random gaps; record its expected block on acceptance
	task automatic send_block(input logic dir, input logic [63:0] blk, input bit known,
			input logic [63:0] known_out);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= dir;
		block_in <= blk;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_blocks.push_back(known ? known_out : xtea_transform(dir, blk));
	endtask

	// Drop valid and wait until every outstanding request has returned
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_blocks.size() != 0);
	endtask

	// Receiver: one long hold-off when armed, random stalls otherwise
	always @(posedge clk) begin
		if (long_hold_armed && !long_hold_taken) begin
			long_hold_taken = 1'b1;
			hold_left = LONG_HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// Check each returned block against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_blocks.size() == 0) begin
				$error("block_out with no request pending: actual %h", block_out);
				error_count++;
			end else begin
				logic [63:0] want;
				want = expected_blocks.pop_front();
				if (block_out !== want) begin
					$error("block_out mismatch: expected %h, actual %h", want, block_out);
					error_count++;
				end
			end
		end
	end

	// End the run when no channel moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic [127:0] cur_key;
		logic [127:0] key;
		logic [5:0]   rounds;
		int           phase_rounds [PHASE_COUNT];

		// Directed table; identity rows run with zero rounds
		cipher_vectors.push_back(cipher_vector(6'd32, '0, OP_ENC, '0, 1'b0, '0));
		cipher_vectors.push_back(cipher_vector(6'd32, '0, OP_ENC, ALL_ONES, 1'b0, '0));
		cipher_vectors.push_back(cipher_vector(6'd32, '0, OP_DEC, '0, 1'b0, '0));
		cipher_vectors.push_back(cipher_vector(6'd32, '0, OP_DEC, ALL_ONES, 1'b0, '0));
		cipher_vectors.push_back(cipher_vector(6'd0, '0, OP_ENC, 64'h0123_4567_89AB_CDEF,
			1'b1, 64'h0123_4567_89AB_CDEF));
		cipher_vectors.push_back(cipher_vector(6'd0, '0, OP_DEC, 64'hFEDC_BA98_7654_3210,
			1'b1, 64'hFEDC_BA98_7654_3210));
		cipher_vectors.push_back(cipher_vector(6'd0, {4{32'hFFFF_FFFF}}, OP_ENC, ALL_ONES,
			1'b1, ALL_ONES));
		cipher_vectors.push_back(cipher_vector(6'd1, {4{32'hFFFF_FFFF}}, OP_ENC, '0, 1'b0, '0));
		cipher_vectors.push_back(cipher_vector(6'd1, {4{32'hFFFF_FFFF}}, OP_DEC, ALL_ONES,
			1'b0, '0));
		cipher_vectors.push_back(cipher_vector(6'd33, {4{32'hFFFF_FFFF}}, OP_ENC,
			64'h8000_0000_0000_0001, 1'b0, '0));
		cipher_vectors.push_back(cipher_vector(6'd63, {4{32'hFFFF_FFFF}}, OP_DEC,
			64'h0000_0001_8000_0000, 1'b0, '0));
		cipher_vectors.push_back(cipher_vector(6'd32,
			128'h0001_0203_0405_0607_0809_0A0B_0C0D_0E0F, OP_ENC, 64'h4142_4344_4546_4748,
			1'b0, '0));
		cipher_vectors.push_back(cipher_vector(6'd32,
			128'h0001_0203_0405_0607_0809_0A0B_0C0D_0E0F, OP_DEC, 64'h4142_4344_4546_4748,
			1'b0, '0));
		cipher_vectors.push_back(cipher_vector(6'd16, {4{32'hAAAA_5555}}, OP_ENC,
			64'h8000_0000_0000_0000, 1'b0, '0));
		cipher_vectors.push_back(cipher_vector(6'd16, {4{32'hAAAA_5555}}, OP_DEC,
			64'h0000_0001_0000_0001, 1'b0, '0));
		cipher_vectors.push_back(cipher_vector(6'd31,
			128'h8000_0000_0000_0001_7FFF_FFFF_FFFF_FFFE, OP_ENC, 64'h5555_5555_AAAA_AAAA,
			1'b0, '0));
		cipher_vectors.push_back(cipher_vector(6'd2,
			128'h8000_0000_0000_0001_7FFF_FFFF_FFFF_FFFE, OP_DEC, 64'hAAAA_AAAA_5555_5555,
			1'b0, '0));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the table; retune the cipher only when a row asks for new settings
		foreach (cipher_vectors[i]) begin
			cur_key = {model_key[0], model_key[1], model_key[2], model_key[3]};
			if (cipher_vectors[i].key != cur_key || cipher_vectors[i].rounds != model_rounds) begin
				drain_results();
				set_cipher(cipher_vectors[i].key, cipher_vectors[i].rounds, '0);
			end
			send_block(cipher_vectors[i].dir, cipher_vectors[i].blk, cipher_vectors[i].known,
				cipher_vectors[i].known_out);
		end
		drain_results();

		// Writes to unused register indexes must leave the settings alone
		for (int idx = CFG_SPARE_FIRST; idx <= CFG_SPARE_LAST; idx++) begin
			write_reg(3'(idx), $urandom());
		end
		for (int i = 0; i < 4; i++) begin
			send_block(1'($urandom()), random_block(), 1'b0, '0);
		end

		// Random phases: fresh key and round count, rotating idle patterns
		phase_rounds = '{32, 1, 0, 63, 33, 17, 0, 0};
		phase_rounds[6] = $urandom_range(1, 32);
		phase_rounds[7] = $urandom_range(1, 32);
		for (int p = 0; p < PHASE_COUNT; p++) begin
			drain_results();
			key = {$urandom(), $urandom(), $urandom(), $urandom()};
			if (p == 1) begin
				key = {4{32'hFFFF_FFFF}};
			end
			rounds = 6'(phase_rounds[p]);
			set_cipher(key, rounds, 26'($urandom()));
			case (p % 4)
				0: begin
					sender_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					sender_idle_pct = 76;
					stall_pct = 0;
				end
				2: begin
					sender_idle_pct = 0;
					stall_pct = 76;
				end
				default: begin
					sender_idle_pct = 23;
					stall_pct = 23;
				end
			endcase
			// Hold the output off while requests keep coming, to back up the queue
			if (p == 0) begin
				long_hold_armed = 1'b1;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_block(1'($urandom()), random_block(), 1'b0, '0);
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_blocks.size() != 0) begin
			$error("block_out missing: %0d results never arrived", expected_blocks.size());
			error_count++;
		end
		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
